// ===== src/qpkt_pkg.sv =====
`default_nettype none
package qpkt_pkg;
  localparam logic [63:0] EMPTY_KEY = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MIX_A = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_B = 64'h94d0_49bb_1331_11eb;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISS     = 2'd2,
    ST_FAIL     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_SIZE_LOG2  = 1'd0,
    CFG_MAX_PROBES = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIX, S_MUL, S_PROBE, S_WAIT, S_CHECK, S_WRITE, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== src/quadratic_probe_key_table.sv =====
`default_nettype none
// channel   ports                                      timing
// input     start, busy, in_kind, in_key               taken when start && !busy
// result    out_valid, out_status, out_slot,           one-cycle strobe
//           out_stored_count
// config    cfg_we, cfg_index, cfg_wdata               written every edge cfg_we is high
// hashing runs two 64-bit products, one after the other, on one 32x32 multiplier;
// each probe then reads the single key RAM port. an insert that claims a slot adds a
// write; at most max_probes+1 probes are made. busy stays high for the whole lookup; a
// reserved key skips hashing and probing. the strobe comes as busy drops.
// after reset a clearing pass writes the empty marker to all 2^TABLE_LOG2 slots,
// one per cycle, with busy high. results cannot be stalled.
module quadratic_probe_key_table #(
  parameter int TABLE_LOG2 = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [63:0] in_key,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_slot,
  output logic [16:0]      out_stored_count,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import qpkt_pkg::*;
  localparam int AW = TABLE_LOG2;

  state_t st_r, st_nxt;
  logic [4:0]  size_r;
  logic [7:0]  maxp_r;
  logic        kind_r;
  logic [63:0] key_r, x_r;
  logic [AW-1:0] idx_r, mask_r;
  logic [8:0]  step_r;
  logic [16:0] cnt_r;
  logic [1:0]  stat_r;
  logic [15:0] slot_r;
  logic        mpass_r;
  logic [AW:0] clr_r;

  logic          mgo, mdone;
  logic [63:0]   mp, rdata;
  logic          we;
  logic [AW-1:0] addr;
  logic [63:0]   wdata;
  logic [4:0]    lg;

  qpkt_mul u_mul (.clk, .rst_n, .go(mgo), .a(x_r), .b(mpass_r ? MIX_B : MIX_A),
                  .done(mdone), .p(mp));
  qpkt_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (.clk, .we, .addr, .wdata, .rdata);

  always_comb begin
    lg = size_r;
    if (lg < 5'd4) lg = 5'd4;
    if (32'(lg) > AW) lg = 5'(AW);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR: if (clr_r[AW]) st_nxt = S_IDLE;
      S_IDLE:  if (start) st_nxt = (in_key == EMPTY_KEY) ? S_DONE : S_MIX;
      S_MIX:   st_nxt = S_MUL;
      S_MUL:   if (mdone) st_nxt = mpass_r ? S_PROBE : S_MIX;
      S_PROBE: st_nxt = S_WAIT;
      S_WAIT:  st_nxt = S_CHECK;
      S_CHECK: begin
        if (rdata == key_r) st_nxt = S_DONE;
        else if (rdata == EMPTY_KEY) st_nxt = kind_r ? S_WRITE : S_DONE;
        else if (step_r[7:0] == maxp_r) st_nxt = S_DONE;
        else st_nxt = S_PROBE;
      end
      S_WRITE: st_nxt = S_DONE;
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (st_r != S_IDLE);
    mgo = (st_r == S_MIX);
    we = 1'b0; addr = idx_r; wdata = key_r;
    case (st_r)
      S_CLEAR: begin we = ~clr_r[AW]; addr = clr_r[AW-1:0]; wdata = EMPTY_KEY; end
      S_WRITE: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; size_r <= 5'd16; maxp_r <= 8'd8;
      cnt_r <= '0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_SIZE_LOG2)) size_r <= cfg_wdata[4:0];
        else maxp_r <= cfg_wdata;
      end
      case (st_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (start) begin
          kind_r <= in_kind; key_r <= in_key; x_r <= in_key ^ (in_key >> 30);
          mpass_r <= 1'b0; step_r <= '0; slot_r <= '0;
          stat_r <= in_kind ? ST_FAIL : ST_MISS;
          mask_r <= AW'((1 << lg) - 1);
        end
        S_MUL: if (mdone) begin
          if (!mpass_r) begin
            x_r <= mp ^ (mp >> 27); mpass_r <= 1'b1;
          end else begin
            idx_r <= AW'(mp ^ (mp >> 31)) & mask_r;
          end
        end
        S_CHECK: begin
          if (rdata == key_r) begin
            stat_r <= ST_FOUND; slot_r <= 16'(idx_r);
          end else if (rdata == EMPTY_KEY) begin
            if (kind_r) begin
              stat_r <= ST_INSERTED; slot_r <= 16'(idx_r); cnt_r <= cnt_r + 1'b1;
            end
          end else begin
            // next triangular offset (s+1)(s+2)/2 with s = step_r
            idx_r <= (idx_r + AW'((17'(step_r) + 17'd1) * (17'(step_r) + 17'd2) >> 1))
                     & mask_r;
            step_r <= step_r + 9'd1;
          end
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_status = stat_r;
  assign out_slot = slot_r;
  assign out_stored_count = cnt_r;
endmodule
`default_nettype wire

// ===== src/qpkt_ram.sv =====
`default_nettype none
module qpkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== src/qpkt_mul.sv =====
`default_nettype none
// 64x64 low-half multiplier from three 32x32 partial products; done pulses as the third lands in the accumulator
module qpkt_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);
  logic [2:0]  ph_r;
  logic [63:0] a_r, b_r, acc_r;
  logic [31:0] x, y;
  logic [63:0] pp_r;
  logic        pv_r;
  logic [1:0]  pph_r;

  always_comb begin
    case (ph_r[1:0])
      2'd0: begin x = a_r[31:0];  y = b_r[31:0]; end
      2'd1: begin x = a_r[31:0];  y = b_r[63:32]; end
      default: begin x = a_r[63:32]; y = b_r[31:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 3'd4; pv_r <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      pv_r <= 1'b0;
      if (go) begin
        a_r <= a; b_r <= b; ph_r <= 3'd0; acc_r <= '0;
      end else if (ph_r < 3'd3) begin
        pp_r  <= 64'(x) * 64'(y);
        pph_r <= ph_r[1:0];
        pv_r  <= 1'b1;
        ph_r  <= ph_r + 3'd1;
      end
      if (pv_r) begin
        if (pph_r == 2'd0) acc_r <= pp_r;
        else acc_r <= acc_r + {pp_r[31:0], 32'd0};
        if (pph_r == 2'd2) done <= 1'b1;
      end
    end
  end
  assign p = acc_r;
endmodule
`default_nettype wire
